>>> src/gradient_noise_2d_macros.svh
// Assertion macros used by the checker file gn2d_chk.sv.
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GN2D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GN2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gn2d_pkg.sv
package gn2d_pkg;

  localparam int GRID_CELLS_DEF = 8;
  localparam int TBL_DEPTH_DEF  = (GRID_CELLS_DEF + 1) * (GRID_CELLS_DEF + 1);

  localparam int PIX_W       = 10;
  localparam int DIM_W       = 10;
  localparam int FRAC_W      = 14;
  localparam int DVD_W       = PIX_W + FRAC_W;
  localparam int DIV_STEP    = 4;
  localparam int DIV_STAGES  = DVD_W / DIV_STEP;
  localparam int IDX_W       = 7;
  localparam int GRAD_W      = 16;
  localparam int GRAD_PAIR_W = 2 * GRAD_W;
  localparam int NOISE_W     = 16;
  localparam int NOISE_MAX   = 16384;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [DIM_W-1:0] CELL_W_RESET = 10'd100;
  localparam logic [DIM_W-1:0] CELL_H_RESET = 10'd75;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH  = 1'b0,
    CFG_CELL_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] y;
    logic signed [GRAD_W-1:0] x;
  } grad_t;

  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [DVD_W-1:0] work;
  } div_st_t;

  // Restoring division, DIV_STEP quotient bits; quotient bits shift into work.
  function automatic div_st_t div_steps(input div_st_t s, input logic [DIM_W-1:0] d);
    div_st_t        r;
    logic [DIM_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r.rem, r.work[DVD_W-1]};
      if (t >= {1'b0, d}) begin
        r.rem  = DIM_W'(t - {1'b0, d});
        r.work = {r.work[DVD_W-2:0], 1'b1};
      end else begin
        r.rem  = t[DIM_W-1:0];
        r.work = {r.work[DVD_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Product scaled back to Q1.14, truncated toward zero.
  function automatic logic signed [33:0] qdiv(input logic signed [47:0] p);
    logic signed [47:0] b;
    b = p + (p[47] ? 48'sd16383 : 48'sd0);
    return 34'(b >>> FRAC_W);
  endfunction

endpackage

>>> src/gn2d_if.sv
interface gn2d_in_if import gn2d_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         grad_index;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [PIX_W-1:0]         pixel_x;
  logic [PIX_W-1:0]         pixel_y;

  modport source(output valid, cmd, grad_index, grad_x, grad_y, pixel_x, pixel_y,
                 input ready);
  modport sink(input valid, cmd, grad_index, grad_x, grad_y, pixel_x, pixel_y,
               output ready);
endinterface

interface gn2d_out_if import gn2d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise;
  logic                      out_of_range;

  modport source(output valid, noise, out_of_range, input ready);
  modport sink(input valid, noise, out_of_range, output ready);
endinterface

>>> src/gn2d_ram.sv
module gn2d_ram
  import gn2d_pkg::*;
#(
  parameter int WIDTH = GRAD_PAIR_W,
  parameter int DEPTH = TBL_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem_r[raddr_a];
      rd_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

>>> src/gradient_noise_2d.sv
// Two-dimensional gradient noise, one beat per cycle.
// The input channel carries two kinds of beat. A write beat (cmd = 0) stores one
// gradient (grad_x, grad_y, Q1.14) at grad_index = row*(GRID_CELLS+1)+column; it
// yields no output beat. A query beat (cmd = 1) gives a pixel and yields one
// output beat with the noise value in Q1.14, or zero with out_of_range set when
// the pixel lies beyond the grid. Load every corner a query touches first.
// Cell sizes are written through cfg_we/cfg_index/cfg_wdata while no beat is in
// flight; a size of zero acts as one.
// Throughput is one beat per cycle. The depth is set by the 24-bit radix-2
// divider for cell and fraction, four quotient bits per stage over six stages,
// followed by an address stage, the table read and six product and sum stages.
// Reset clears all stage valid bits and sets the cell sizes to 100 by 75 pixels;
// the gradient table keeps its contents. When the receiver stalls, the pipeline
// keeps filling its empty stages and input ready drops only once all are full.
module gradient_noise_2d
  import gn2d_pkg::*;
#(
  parameter int GRID_CELLS = GRID_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gn2d_in_if.sink               in_ch,
  gn2d_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TBL_SIDE  = GRID_CELLS + 1;
  localparam int TBL_DEPTH = TBL_SIDE * TBL_SIDE;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int CX_W      = $clog2(TBL_SIDE);
  localparam int S_ADR     = DIV_STAGES;
  localparam int S_RD      = S_ADR + 1;
  localparam int S_DP      = S_ADR + 2;
  localparam int S_DOT     = S_ADR + 3;
  localparam int S_L1P     = S_ADR + 4;
  localparam int S_L1      = S_ADR + 5;
  localparam int S_L2P     = S_ADR + 6;
  localparam int S_OUT     = S_ADR + 7;
  localparam int NSTG      = S_OUT + 1;

  logic [DIM_W-1:0] cell_w_r;
  logic [DIM_W-1:0] cell_h_r;
  logic [DIM_W-1:0] div_w;
  logic [DIM_W-1:0] div_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_w_r <= CELL_W_RESET;
      cell_h_r <= CELL_H_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CELL_WIDTH:  cell_w_r <= cfg_wdata;
        CFG_CELL_HEIGHT: cell_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign div_w = (cell_w_r == '0) ? DIM_W'(1) : cell_w_r;
  assign div_h = (cell_h_r == '0) ? DIM_W'(1) : cell_h_r;

  // A stage loads when some stage from it to the output is empty or the output
  // beat is taken.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] en;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !(&v_r[NSTG-1:k]) || out_ch.ready;
  end

  assign in_ch.ready = en[0];

  // Divider and write-beat carry.
  div_st_t          seed_x;
  div_st_t          seed_y;
  div_st_t          dx_r   [DIV_STAGES];
  div_st_t          dy_r   [DIV_STAGES];
  div_st_t          dx_nxt [DIV_STAGES];
  div_st_t          dy_nxt [DIV_STAGES];
  logic             wr_r   [S_ADR+1];
  logic [IDX_W-1:0] idx_r  [S_ADR+1];
  grad_t            grad_r [S_ADR+1];

  assign seed_x.rem  = '0;
  assign seed_x.work = {in_ch.pixel_x, {FRAC_W{1'b0}}};
  assign seed_y.rem  = '0;
  assign seed_y.work = {in_ch.pixel_y, {FRAC_W{1'b0}}};

  always_comb begin
    dx_nxt[0] = div_steps(seed_x, div_w);
    dy_nxt[0] = div_steps(seed_y, div_h);
    for (int k = 1; k < DIV_STAGES; k++) begin
      dx_nxt[k] = div_steps(dx_r[k-1], div_w);
      dy_nxt[k] = div_steps(dy_r[k-1], div_h);
    end
  end

  // Address stage.
  logic [DVD_W-1:0]  qx;
  logic [DVD_W-1:0]  qy;
  logic              oor_nxt;
  logic [CX_W-1:0]   cx_n;
  logic [CX_W-1:0]   cy_n;
  logic [ADDR_W-1:0] a00_nxt;
  logic [ADDR_W-1:0] a00_r;
  logic [ADDR_W-1:0] a10_r;
  logic [ADDR_W-1:0] a01_r;
  logic [ADDR_W-1:0] a11_r;
  logic [FRAC_W-1:0] t_nxt [2];
  logic [FRAC_W-1:0] t_r   [S_ADR:S_RD][2];
  logic              oor_r [S_ADR:S_OUT];

  logic signed [19:0] fa   [2];
  logic signed [34:0] m1_nxt [2];
  logic signed [34:0] m1_r   [2];
  logic [27:0]        m2_nxt [2];
  logic [27:0]        m2_r   [2];

  assign qx      = dx_r[DIV_STAGES-1].work;
  assign qy      = dy_r[DIV_STAGES-1].work;
  assign t_nxt[0] = qx[FRAC_W-1:0];
  assign t_nxt[1] = qy[FRAC_W-1:0];
  assign oor_nxt = (qx[DVD_W-1:FRAC_W] >= PIX_W'(GRID_CELLS)) ||
                   (qy[DVD_W-1:FRAC_W] >= PIX_W'(GRID_CELLS));
  assign cx_n    = oor_nxt ? '0 : CX_W'(qx[DVD_W-1:FRAC_W]);
  assign cy_n    = oor_nxt ? '0 : CX_W'(qy[DVD_W-1:FRAC_W]);
  assign a00_nxt = ADDR_W'(cy_n) * ADDR_W'(TBL_SIDE) + ADDR_W'(cx_n);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fa[l]     = 20'sd6 * $signed({6'b0, t_nxt[l]}) - 20'sd245760;
      m1_nxt[l] = 35'($signed({1'b0, t_nxt[l]})) * 35'(fa[l]);
      m2_nxt[l] = 28'(t_nxt[l]) * 28'(t_nxt[l]);
    end
  end

  // Table read stage.
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [GRAD_PAIR_W-1:0] rdata [4];
  logic signed [19:0]     b_nxt [2];
  logic signed [19:0]     b_r   [2];
  logic [27:0]            m3_nxt [2];
  logic [27:0]            m3_r   [2];

  assign ram_we    = v_r[S_ADR] && wr_r[S_ADR] && en[S_RD] &&
                     (32'(idx_r[S_ADR]) < 32'(TBL_DEPTH));
  assign ram_waddr = ADDR_W'(idx_r[S_ADR]);

  gn2d_ram #(
    .WIDTH (GRAD_PAIR_W),
    .DEPTH (TBL_DEPTH)
  ) u_ram_row0 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (grad_r[S_ADR]),
    .re      (en[S_RD]),
    .raddr_a (a00_r),
    .raddr_b (a10_r),
    .rdata_a (rdata[0]),
    .rdata_b (rdata[1])
  );

  gn2d_ram #(
    .WIDTH (GRAD_PAIR_W),
    .DEPTH (TBL_DEPTH)
  ) u_ram_row1 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (grad_r[S_ADR]),
    .re      (en[S_RD]),
    .raddr_a (a01_r),
    .raddr_b (a11_r),
    .rdata_a (rdata[2]),
    .rdata_b (rdata[3])
  );

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      b_nxt[l]  = 20'(qdiv(48'(m1_r[l]))) + 20'sd163840;
      m3_nxt[l] = 28'(m2_r[l] >> FRAC_W) * 28'(t_r[S_ADR][l]);
    end
  end

  // Corner products and last fade product. Corners: 0 = (0,0), 1 = (1,0),
  // 2 = (0,1), 3 = (1,1).
  logic signed [GRAD_W-1:0] off_lo [2];
  logic signed [GRAD_W-1:0] off_hi [2];
  grad_t                    g      [4];
  logic signed [31:0]       p_nxt  [4][2];
  logic signed [31:0]       p_r    [4][2];
  logic signed [34:0]       m4_nxt [2];
  logic signed [34:0]       m4_r   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      off_lo[l] = $signed({2'b0, t_r[S_RD][l]});
      off_hi[l] = off_lo[l] - 16'sd16384;
      m4_nxt[l] = 35'($signed({1'b0, FRAC_W'(m3_r[l] >> FRAC_W)})) * 35'(b_r[l]);
    end
    for (int c = 0; c < 4; c++) begin
      g[c]        = grad_t'(rdata[c]);
      p_nxt[c][0] = 32'(g[c].x) * 32'(c[0] ? off_hi[0] : off_lo[0]);
      p_nxt[c][1] = 32'(g[c].y) * 32'(c[1] ? off_hi[1] : off_lo[1]);
    end
  end

  // Dot products and fade values.
  logic signed [18:0] dot_nxt  [4];
  logic signed [18:0] dot_r    [4];
  logic signed [18:0] fade_nxt [2];
  logic signed [18:0] fade_r   [2];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dot_nxt[c] = 19'(qdiv(48'(p_r[c][0]))) + 19'(qdiv(48'(p_r[c][1])));
    end
    for (int l = 0; l < 2; l++) begin
      fade_nxt[l] = 19'(qdiv(48'(m4_r[l])));
    end
  end

  // Interpolation along x, then along y.
  logic signed [19:0] wx;
  logic signed [38:0] lp_nxt [4];
  logic signed [38:0] lp_r   [4];
  logic signed [18:0] fy_r   [S_L1P:S_L1];
  logic signed [25:0] n_nxt  [2];
  logic signed [25:0] n_r    [2];
  logic signed [19:0] wy;
  logic signed [45:0] q_nxt  [2];
  logic signed [45:0] q_r    [2];
  logic signed [32:0] sum;
  logic signed [NOISE_W-1:0] noise_nxt;
  logic signed [NOISE_W-1:0] noise_r;

  assign wx = 20'sd16384 - 20'(fade_r[0]);
  assign wy = 20'sd16384 - 20'(fy_r[S_L1]);

  always_comb begin
    lp_nxt[0] = 39'(dot_r[0]) * 39'(wx);
    lp_nxt[1] = 39'(dot_r[1]) * 39'(fade_r[0]);
    lp_nxt[2] = 39'(dot_r[2]) * 39'(wx);
    lp_nxt[3] = 39'(dot_r[3]) * 39'(fade_r[0]);
    n_nxt[0]  = 26'(qdiv(48'(lp_r[0]))) + 26'(qdiv(48'(lp_r[1])));
    n_nxt[1]  = 26'(qdiv(48'(lp_r[2]))) + 26'(qdiv(48'(lp_r[3])));
    q_nxt[0]  = 46'(n_r[0]) * 46'(wy);
    q_nxt[1]  = 46'(n_r[1]) * 46'(fy_r[S_L1]);
    sum       = 33'(qdiv(48'(q_r[0]))) + 33'(qdiv(48'(q_r[1])));
    if (oor_r[S_L2P]) begin
      noise_nxt = '0;
    end else if (sum > 33'sd16384) begin
      noise_nxt = 16'sd16384;
    end else if (sum < -33'sd16384) begin
      noise_nxt = -16'sd16384;
    end else begin
      noise_nxt = NOISE_W'(sum);
    end
  end

  // Valid bits. Write beats leave the pipeline once the table is written.
  always_comb begin
    v_nxt[0] = in_ch.valid;
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = v_r[k-1];
    end
    v_nxt[S_RD] = v_r[S_ADR] && !wr_r[S_ADR];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        dx_r[k] <= dx_nxt[k];
        dy_r[k] <= dy_nxt[k];
      end
    end
    if (en[0]) begin
      wr_r[0]     <= (in_ch.cmd == CMD_WRITE);
      idx_r[0]    <= in_ch.grad_index;
      grad_r[0].x <= in_ch.grad_x;
      grad_r[0].y <= in_ch.grad_y;
    end
    for (int k = 1; k <= S_ADR; k++) begin
      if (en[k]) begin
        wr_r[k]   <= wr_r[k-1];
        idx_r[k]  <= idx_r[k-1];
        grad_r[k] <= grad_r[k-1];
      end
    end
    if (en[S_ADR]) begin
      oor_r[S_ADR] <= oor_nxt;
      a00_r        <= a00_nxt;
      a10_r        <= a00_nxt + ADDR_W'(1);
      a01_r        <= a00_nxt + ADDR_W'(TBL_SIDE);
      a11_r        <= a00_nxt + ADDR_W'(TBL_SIDE + 1);
      t_r[S_ADR]   <= t_nxt;
      m1_r         <= m1_nxt;
      m2_r         <= m2_nxt;
    end
    if (en[S_RD]) begin
      t_r[S_RD] <= t_r[S_ADR];
      b_r       <= b_nxt;
      m3_r      <= m3_nxt;
    end
    if (en[S_DP]) begin
      p_r  <= p_nxt;
      m4_r <= m4_nxt;
    end
    if (en[S_DOT]) begin
      dot_r  <= dot_nxt;
      fade_r <= fade_nxt;
    end
    if (en[S_L1P]) begin
      lp_r        <= lp_nxt;
      fy_r[S_L1P] <= fade_r[1];
    end
    if (en[S_L1]) begin
      n_r        <= n_nxt;
      fy_r[S_L1] <= fy_r[S_L1P];
    end
    if (en[S_L2P]) begin
      q_r <= q_nxt;
    end
    if (en[S_OUT]) begin
      noise_r <= noise_nxt;
    end
    for (int k = S_ADR + 1; k <= S_OUT; k++) begin
      if (en[k]) begin
        oor_r[k] <= oor_r[k-1];
      end
    end
  end

  assign out_ch.valid        = v_r[S_OUT];
  assign out_ch.noise        = noise_r;
  assign out_ch.out_of_range = oor_r[S_OUT];

endmodule

>>> src/gn2d_chk.sv
`include "gradient_noise_2d_macros.svh"

module gn2d_chk
  import gn2d_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [NOISE_W-1:0] out_noise,
  input logic                      out_of_range
);

  `GN2D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_noise) && $stable(out_of_range), "stalled output beat changed")
  `GN2D_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_of_range, out_noise == '0, "out of range beat carries nonzero noise")
  `GN2D_ASSERT_NOW(a_noise_sat, clk, rst_n, out_valid, (out_noise <= NOISE_MAX) && (out_noise >= -NOISE_MAX), "noise outside saturation range")
  `GN2D_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled while output is free")
  `GN2D_ASSERT_NOW(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid, "output beat right after reset")

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind gradient_noise_2d gn2d_chk u_gn2d_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_noise    (out_ch.noise),
  .out_of_range (out_ch.out_of_range)
);

>>> tb/sv/noise_compare.sv
`timescale 1ns / 1ps

module noise_compare
  import gn2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  gn2d_in_if                    in_ch,
  gn2d_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           backlog,
  output int unsigned           fail_count
);

  localparam longint QONE = NOISE_MAX;
  localparam int     SIDE = GRID_CELLS_DEF + 1;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic                      out_of_range;
  } noise_beat_t;

  grad_t            corner_grad [TBL_DEPTH_DEF];
  logic [DIM_W-1:0] cell_w;
  logic [DIM_W-1:0] cell_h;
  noise_beat_t      noise_due_q [$];

  initial begin
    for (int i = 0; i < TBL_DEPTH_DEF; i++) begin
      corner_grad[i] = '0;
    end
  end

  function automatic longint qscale(input longint a, input longint b);
    return (a * b) / QONE;
  endfunction

  function automatic longint fade_q(input longint t);
    longint a;
    longint b;
    longint t3;
    a  = t * 6 - 15 * QONE;
    b  = qscale(t, a) + 10 * QONE;
    t3 = qscale(qscale(t, t), t);
    return qscale(t3, b);
  endfunction

  function automatic longint lerp_q(input longint a, input longint b, input longint f);
    return qscale(a, QONE - f) + qscale(b, f);
  endfunction

  function automatic longint corner_dot(input int idx, input longint dx, input longint dy);
    grad_t g;
    g = corner_grad[idx];
    return qscale(longint'(g.x), dx) + qscale(longint'(g.y), dy);
  endfunction

  function automatic noise_beat_t predict_noise(input logic [PIX_W-1:0] pix_x,
                                                input logic [PIX_W-1:0] pix_y);
    noise_beat_t r;
    int          px;
    int          py;
    int          cw;
    int          ch;
    int          cx;
    int          cy;
    int          i00;
    longint      tx;
    longint      ty;
    longint      n00;
    longint      n10;
    longint      n01;
    longint      n11;
    longint      fx;
    longint      fy;
    longint      n;
    px = pix_x;
    py = pix_y;
    cw = (cell_w == 0) ? 1 : cell_w;
    ch = (cell_h == 0) ? 1 : cell_h;
    cx = px / cw;
    cy = py / ch;
    if (cx >= GRID_CELLS_DEF || cy >= GRID_CELLS_DEF) begin
      r.noise        = '0;
      r.out_of_range = 1'b1;
      return r;
    end
    tx  = longint'((px % cw) * NOISE_MAX / cw);
    ty  = longint'((py % ch) * NOISE_MAX / ch);
    i00 = cy * SIDE + cx;
    n00 = corner_dot(i00, tx, ty);
    n10 = corner_dot(i00 + 1, tx - QONE, ty);
    n01 = corner_dot(i00 + SIDE, tx, ty - QONE);
    n11 = corner_dot(i00 + SIDE + 1, tx - QONE, ty - QONE);
    fx  = fade_q(tx);
    fy  = fade_q(ty);
    n   = lerp_q(lerp_q(n00, n10, fx), lerp_q(n01, n11, fx), fy);
    if (n > QONE) begin
      n = QONE;
    end
    if (n < -QONE) begin
      n = -QONE;
    end
    r.noise        = NOISE_W'(n);
    r.out_of_range = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    noise_beat_t want;
    if (!rst_n) begin
      cell_w     <= CELL_W_RESET;
      cell_h     <= CELL_H_RESET;
      noise_due_q.delete();
      backlog    <= 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CELL_WIDTH: begin
            cell_w <= cfg_wdata;
          end
          CFG_CELL_HEIGHT: begin
            cell_h <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_WRITE) begin
          if (in_ch.grad_index < TBL_DEPTH_DEF) begin
            corner_grad[in_ch.grad_index] <= '{y: in_ch.grad_y, x: in_ch.grad_x};
          end
        end else begin
          noise_due_q.push_back(predict_noise(in_ch.pixel_x, in_ch.pixel_y));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (noise_due_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected beat: noise %0d out_of_range %0b",
                     out_ch.noise, out_ch.out_of_range);
          end
          fail_count++;
        end else begin
          want = noise_due_q.pop_front();
          if (out_ch.noise !== want.noise || out_ch.out_of_range !== want.out_of_range) begin
            if (fail_count < 10) begin
              $display("mismatch: expected noise %0d out_of_range %0b, got noise %0d out_of_range %0b",
                       want.noise, want.out_of_range, out_ch.noise, out_ch.out_of_range);
            end
            fail_count++;
          end
        end
      end
      backlog <= noise_due_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gn2d_pkg::*;

  localparam int SIDE        = GRID_CELLS_DEF + 1;
  localparam int PHASE_BEATS = 62;
  localparam int SETTLE      = 24;
  localparam int LIMIT       = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  calm;
  int unsigned           backlog;
  int unsigned           fail_count;
  int unsigned           cycles = 0;
  logic [DIM_W-1:0]      cur_w;
  logic [DIM_W-1:0]      cur_h;

  gn2d_in_if  in_ch ();
  gn2d_out_if out_ch ();

  gradient_noise_2d uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  noise_compare compare (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .backlog    (backlog),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 32);
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [GRAD_W-1:0] gx,
                           input logic signed [GRAD_W-1:0] gy,
                           input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.grad_index <= idx;
    in_ch.grad_x     <= gx;
    in_ch.grad_y     <= gy;
    in_ch.pixel_x    <= px;
    in_ch.pixel_y    <= py;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic load_corner(input int idx, input int gx, input int gy);
    send_beat(CMD_WRITE, IDX_W'(idx), GRAD_W'(gx), GRAD_W'(gy),
              PIX_W'($urandom), PIX_W'($urandom));
  endtask

  task automatic query(input int px, input int py);
    send_beat(CMD_QUERY, IDX_W'($urandom), GRAD_W'($urandom), GRAD_W'($urandom),
              PIX_W'(px), PIX_W'(py));
  endtask

  // Writes yield no beat, so a fixed settle time follows the last result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (backlog != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cell_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CELL_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_CELL_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  function automatic int pick_pixel(input logic [DIM_W-1:0] size);
    int span;
    span = GRID_CELLS_DEF * ((size == 0) ? 1 : int'(size));
    if (span > 1024) begin
      span = 1024;
    end
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(0, span - 1);
    end
    return $urandom_range(0, 1023);
  endfunction

  function automatic int rand_grad();
    return int'($urandom_range(0, 2 * NOISE_MAX)) - NOISE_MAX;
  endfunction

  initial begin
    logic [DIM_W-1:0] phase_w [8];
    logic [DIM_W-1:0] phase_h [8];
    int               idx;
    phase_w = '{10'd1, 10'd1023, 10'd0, 10'd37, 10'd128, 10'd3, 10'd0, 10'd100};
    phase_h = '{10'd1, 10'd1023, 10'd0, 10'd90, 10'd128, 10'd1023, 10'd0, 10'd75};
    phase_w[6] = DIM_W'($urandom_range(1, 1023));
    phase_h[6] = DIM_W'($urandom_range(1, 1023));
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_CELL_WIDTH;
    cfg_wdata        <= '0;
    calm             <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_WRITE;
    in_ch.grad_index <= '0;
    in_ch.grad_x     <= '0;
    in_ch.grad_y     <= '0;
    in_ch.pixel_x    <= '0;
    in_ch.pixel_y    <= '0;
    cur_w = CELL_W_RESET;
    cur_h = CELL_H_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Signs alternate by column and row, so cell (0,0) peaks near +1 and cell (1,1) near -1.
    for (int i = 0; i < TBL_DEPTH_DEF; i++) begin
      load_corner(i, ((i % SIDE) % 2 != 0) ? -NOISE_MAX : NOISE_MAX,
                  ((i / SIDE) % 2 != 0) ? -NOISE_MAX : NOISE_MAX);
    end
    query(0, 0);
    query(50, 37);
    query(150, 112);
    query(99, 74);
    query(100, 75);
    query(799, 599);
    query(800, 0);
    query(0, 600);
    query(1023, 1023);
    load_corner(81, NOISE_MAX, NOISE_MAX);
    load_corner(127, -NOISE_MAX, -NOISE_MAX);
    query(60, 40);
    load_corner(0, -NOISE_MAX, NOISE_MAX);
    query(10, 10);
    load_corner(0, 0, 0);
    query(10, 10);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_cell_size(phase_w[p], phase_h[p]);
      calm <= (p == 4);
      for (int n = 0; n < PHASE_BEATS; ) begin
        if ($urandom_range(0, 99) < 12) begin
          idx = $urandom_range(0, 127);
          load_corner(idx, rand_grad(), rand_grad());
          if (idx < TBL_DEPTH_DEF) begin
            n++;
          end
        end else begin
          query(pick_pixel(cur_w), pick_pixel(cur_h));
          n++;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> gradient_noise_2d.f
+incdir+src
src/gn2d_pkg.sv
src/gn2d_if.sv
src/gn2d_ram.sv
src/gradient_noise_2d.sv
src/gn2d_chk.sv
tb/sv/noise_compare.sv
tb/sv/tb.sv
